// ===== hw/rtl/serial_frame_payload_extractor_defines.svh =====
// Assertion macros used by the frame extractor checker.
// No dependencies; include by bare file name.
`ifndef SERIAL_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH
`define SERIAL_FRAME_PAYLOAD_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define SFPE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SFPE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/sfpe_pkg.sv =====
// Shared types and constants for the serial frame payload extractor.
// No dependencies.
`default_nettype none

package sfpe_pkg;

   localparam logic [7:0]  HDR_FIRST       = 8'h55;
   localparam logic [7:0]  HDR_SECOND      = 8'hAA;
   localparam logic [7:0]  WANTED_CMD_RST  = 8'h01;
   localparam logic [15:0] MAX_LEN_RST     = 16'd256;

   // Register indexes on the configuration port
   localparam logic CSR_WANTED_COMMAND = 1'b0;
   localparam logic CSR_MAX_LENGTH     = 1'b1;

   // Result item kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_VERDICT = 1'b1;

   typedef enum logic [2:0] {
      PH_HDR1 = 3'd0,
      PH_HDR2 = 3'd1,
      PH_VER  = 3'd2,
      PH_CMD  = 3'd3,
      PH_LENH = 3'd4,
      PH_LENL = 3'd5,
      PH_PAY  = 3'd6,
      PH_SUM  = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0]  wanted_command;
      logic [15:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic       item_kind;
      logic [7:0] payload_data;
      logic       frame_good;
      logic       last;
   } result_type;

endpackage

`default_nettype wire

// ===== hw/rtl/sfpe_csr.sv =====
// Configuration registers of the frame extractor.
// Depends on sfpe_pkg.
`default_nettype none

module sfpe_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_data,
   output sfpe_pkg::cfg_type     cfg
);

   sfpe_pkg::cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            sfpe_pkg::CSR_WANTED_COMMAND: cfg_in.wanted_command = csr_data[7:0];
            sfpe_pkg::CSR_MAX_LENGTH:     cfg_in.max_payload_length = csr_data;
            default:                      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.wanted_command     <= sfpe_pkg::WANTED_CMD_RST;
         cfg_ff.max_payload_length <= sfpe_pkg::MAX_LEN_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfpe_in_reg.sv =====
// Input register of the frame extractor: holds one received byte.
// Depends on nothing but the ports.
`default_nettype none

module sfpe_in_reg (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,
   input  wire logic       advance,
   output logic            byte_valid,
   output logic [7:0]      rx_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff,  byte_in;

   // Take a new item whenever the held one is empty or leaves this cycle
   assign req_tready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
         byte_in  = req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign byte_valid = valid_ff;
   assign rx_byte    = byte_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/sfpe_parser.sv =====
// Frame parser state machine: header, length, payload and checksum tracking.
// Depends on sfpe_pkg.
`default_nettype none

module sfpe_parser (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire logic [7:0]        rx_byte,
   input  wire sfpe_pkg::cfg_type cfg,
   output logic                   result_valid,
   output sfpe_pkg::result_type   result
);

   sfpe_pkg::phase_type phase_ff, phase_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  sum_ff,     sum_in;
   logic [15:0] length_ff,  length_in;
   logic [15:0] seen_ff,    seen_in;
   logic        captured_ff, captured_in;

   logic        is_first;
   logic        extracting;
   logic [7:0]  sum_add;
   logic [15:0] seen_inc;
   logic        good;
   logic        restart;

   assign is_first   = (rx_byte == sfpe_pkg::HDR_FIRST);
   assign extracting = (command_ff == cfg.wanted_command) && (length_ff != 16'd0)
                       && (length_ff <= cfg.max_payload_length);
   assign sum_add    = sum_ff + rx_byte;
   assign seen_inc   = seen_ff + 16'd1;
   assign good       = (rx_byte == sum_ff);

   // Restart on this byte: in header one, on a bad second header byte,
   // and on any checksum byte that does not capture.
   always_comb begin
      case (phase_ff)
         sfpe_pkg::PH_HDR1: restart = 1'b1;
         sfpe_pkg::PH_HDR2: restart = (rx_byte != sfpe_pkg::HDR_SECOND);
         sfpe_pkg::PH_SUM:  restart = !(extracting && good);
         default:           restart = 1'b0;
      endcase
   end

   // Next phase
   always_comb begin
      phase_in = phase_ff;
      if (step && !captured_ff) begin
         if (restart) begin
            phase_in = is_first ? sfpe_pkg::PH_HDR2 : sfpe_pkg::PH_HDR1;
         end else begin
            case (phase_ff)
               sfpe_pkg::PH_HDR2: phase_in = sfpe_pkg::PH_VER;
               sfpe_pkg::PH_VER:  phase_in = sfpe_pkg::PH_CMD;
               sfpe_pkg::PH_CMD:  phase_in = sfpe_pkg::PH_LENH;
               sfpe_pkg::PH_LENH: phase_in = sfpe_pkg::PH_LENL;
               sfpe_pkg::PH_LENL: begin
                  phase_in = ({length_ff[15:8], rx_byte} == 16'd0) ?
                             sfpe_pkg::PH_SUM : sfpe_pkg::PH_PAY;
               end
               sfpe_pkg::PH_PAY: begin
                  if (seen_inc == length_ff) phase_in = sfpe_pkg::PH_SUM;
               end
               default:           phase_in = phase_ff;
            endcase
         end
      end
   end

   // Frame fields, checksum and result
   always_comb begin
      command_in   = command_ff;
      sum_in       = sum_ff;
      length_in    = length_ff;
      seen_in      = seen_ff;
      captured_in  = captured_ff;
      result_valid = 1'b0;
      result       = '0;
      if (step && !captured_ff) begin
         if (phase_ff == sfpe_pkg::PH_SUM && extracting) begin
            result_valid      = 1'b1;
            result.item_kind  = sfpe_pkg::KIND_VERDICT;
            result.frame_good = good;
            result.last       = 1'b1;
            captured_in       = good;
         end
         if (restart) begin
            command_in = 8'd0;
            length_in  = 16'd0;
            seen_in    = 16'd0;
            sum_in     = is_first ? sfpe_pkg::HDR_FIRST : 8'd0;
         end else begin
            case (phase_ff)
               sfpe_pkg::PH_CMD: begin
                  command_in = rx_byte;
                  sum_in     = sum_add;
               end
               sfpe_pkg::PH_LENH: begin
                  length_in = {rx_byte, 8'd0};
                  sum_in    = sum_add;
               end
               sfpe_pkg::PH_LENL: begin
                  length_in = {length_ff[15:8], rx_byte};
                  seen_in   = 16'd0;
                  sum_in    = sum_add;
               end
               sfpe_pkg::PH_PAY: begin
                  sum_in  = sum_add;
                  seen_in = seen_inc;
                  if (extracting) begin
                     result_valid        = 1'b1;
                     result.item_kind    = sfpe_pkg::KIND_PAYLOAD;
                     result.payload_data = rx_byte;
                  end
               end
               sfpe_pkg::PH_SUM:  sum_in = sum_ff;
               default:           sum_in = sum_add;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= sfpe_pkg::PH_HDR1;
         command_ff  <= 8'd0;
         sum_ff      <= 8'd0;
         length_ff   <= 16'd0;
         seen_ff     <= 16'd0;
         captured_ff <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         command_ff  <= command_in;
         sum_ff      <= sum_in;
         length_ff   <= length_in;
         seen_ff     <= seen_in;
         captured_ff <= captured_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/sfpe_out_reg.sv =====
// Result register of the frame extractor, drives the result stream.
// Depends on sfpe_pkg.
`default_nettype none

module sfpe_out_reg (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      advance,
   input  wire logic                 result_valid,
   input  wire sfpe_pkg::result_type result,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [15:0]               rsp_tdata,
   output logic                      rsp_tuser,
   output logic                      rsp_tlast
);

   logic                 valid_ff, valid_in;
   sfpe_pkg::result_type data_ff,  data_in;

   // The parser may step when the result slot is free or drains this cycle
   assign advance = in_valid && (!valid_ff || rsp_tready);

   always_comb begin
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      if (advance && result_valid) begin
         valid_in = 1'b1;
         data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, data_ff.frame_good, data_ff.payload_data};
   assign rsp_tuser  = data_ff.item_kind;
   assign rsp_tlast  = data_ff.last;

endmodule

`default_nettype wire

// ===== hw/rtl/serial_frame_payload_extractor.sv =====
// Serial frame payload extractor: takes one received byte per item and parses
// frames of 0x55 0xAA, version, command, big-endian 16-bit length, payload and
// an 8-bit additive checksum; payload bytes of frames with the configured
// command and a length from 1 to the limit come out as kind-0 items, and the
// checksum byte gives a kind-1 verdict item marked last. A good verdict makes
// the block ignore all later bytes until reset. One byte is accepted every
// cycle while results drain; a byte goes from the input register through
// the parser step into the result register, which drives the result port.
// A result held by a stalled receiver stops the input once the input
// register is full as well.
// Depends on sfpe_pkg, sfpe_csr, sfpe_in_reg, sfpe_parser and sfpe_out_reg.
`default_nettype none

module serial_frame_payload_extractor (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] payload_data, [8] frame_good
   output logic             rsp_tuser,   // [0] item_kind
   output logic             rsp_tlast,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_data
);

   sfpe_pkg::cfg_type    cfg;
   sfpe_pkg::result_type result;
   logic                 result_valid;
   logic                 byte_valid;
   logic [7:0]           rx_byte;
   logic                 advance;

   sfpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   sfpe_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .byte_valid (byte_valid),
      .rx_byte    (rx_byte)
   );

   sfpe_parser u_parser (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .rx_byte      (rx_byte),
      .cfg          (cfg),
      .result_valid (result_valid),
      .result       (result)
   );

   sfpe_out_reg u_out_reg (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (byte_valid),
      .advance      (advance),
      .result_valid (result_valid),
      .result       (result),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/sfpe_checker.sv =====
// Port-level checker for the serial frame payload extractor, bound to the top.
// Depends on serial_frame_payload_extractor_defines.svh.
`default_nettype none
`include "serial_frame_payload_extractor_defines.svh"

module sfpe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata,
   input wire logic        rsp_tuser,
   input wire logic        rsp_tlast
);

   `SFPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "result changed while stalled")
   `SFPE_ASSERT_NOW(a_payload_shape, clock, reset, rsp_tvalid && !rsp_tuser, !rsp_tlast && !rsp_tdata[8] && rsp_tdata[15:9] == 7'd0, "payload item carries verdict bits")
   `SFPE_ASSERT_NOW(a_verdict_shape, clock, reset, rsp_tvalid && rsp_tuser, rsp_tlast && rsp_tdata[7:0] == 8'd0 && rsp_tdata[15:9] == 7'd0, "verdict item malformed")
   `SFPE_ASSERT_NEXT(a_quiet_after_capture, clock, reset, rsp_tvalid && rsp_tready && rsp_tuser && rsp_tdata[8], !rsp_tvalid, "item after good verdict")

endmodule

bind serial_frame_payload_extractor sfpe_checker u_sfpe_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

`default_nettype wire

// ===== verif/serial_frame_payload_extractor_tb.sv =====
// Self-checking testbench for serial_frame_payload_extractor: random serial frames,
// noise and config changes, checked item by item against a parser model in the bench.
// Depends on sfpe_pkg and the serial_frame_payload_extractor RTL.
module serial_frame_payload_extractor_tb;

   localparam int CYCLE_LIMIT = 250000;

   class extractor_scoreboard;
      logic [7:0]           wanted_cmd;
      logic [15:0]          len_limit;
      sfpe_pkg::phase_type  parse_phase;
      logic [7:0]           frame_cmd;
      logic [7:0]           frame_sum;
      logic [15:0]          frame_len;
      logic [15:0]          bytes_seen;
      bit                   captured;
      sfpe_pkg::result_type expected_items[$];
      int                   errors;
      int                   items_checked;

      function new();
         wanted_cmd  = sfpe_pkg::WANTED_CMD_RST;
         len_limit   = sfpe_pkg::MAX_LEN_RST;
         captured    = 1'b0;
         errors      = 0;
         items_checked = 0;
         restart_on(8'h00);
      endfunction

      function void set_reg(logic idx, logic [15:0] value);
         if (idx == sfpe_pkg::CSR_WANTED_COMMAND) wanted_cmd = value[7:0];
         else len_limit = value;
      endfunction

      // Clear the frame; a 0x55 immediately opens a new header.
      function void restart_on(logic [7:0] b);
         parse_phase = sfpe_pkg::PH_HDR1;
         frame_cmd   = 8'h00;
         frame_sum   = 8'h00;
         frame_len   = 16'h0000;
         bytes_seen  = 16'h0000;
         if (b == sfpe_pkg::HDR_FIRST) begin
            frame_sum   = sfpe_pkg::HDR_FIRST;
            parse_phase = sfpe_pkg::PH_HDR2;
         end
      endfunction

      function bit extracting();
         return frame_cmd == wanted_cmd && frame_len != 16'h0000 && frame_len <= len_limit;
      endfunction

      function void parse_byte(logic [7:0] b);
         sfpe_pkg::result_type r;
         if (captured) return;
         r = '0;
         case (parse_phase)
            sfpe_pkg::PH_HDR1: restart_on(b);
            sfpe_pkg::PH_HDR2: begin
               if (b != sfpe_pkg::HDR_SECOND) begin
                  restart_on(b);
               end else begin
                  frame_sum   = frame_sum + b;
                  parse_phase = sfpe_pkg::PH_VER;
               end
            end
            sfpe_pkg::PH_VER: begin
               frame_sum   = frame_sum + b;
               parse_phase = sfpe_pkg::PH_CMD;
            end
            sfpe_pkg::PH_CMD: begin
               frame_cmd   = b;
               frame_sum   = frame_sum + b;
               parse_phase = sfpe_pkg::PH_LENH;
            end
            sfpe_pkg::PH_LENH: begin
               frame_len   = {b, 8'h00};
               frame_sum   = frame_sum + b;
               parse_phase = sfpe_pkg::PH_LENL;
            end
            sfpe_pkg::PH_LENL: begin
               frame_len[7:0] = b;
               frame_sum      = frame_sum + b;
               bytes_seen     = 16'h0000;
               if (frame_len == 16'h0000) parse_phase = sfpe_pkg::PH_SUM;
               else parse_phase = sfpe_pkg::PH_PAY;
            end
            sfpe_pkg::PH_PAY: begin
               frame_sum = frame_sum + b;
               if (extracting()) begin
                  r.item_kind    = sfpe_pkg::KIND_PAYLOAD;
                  r.payload_data = b;
                  expected_items = {expected_items, r};
               end
               bytes_seen = bytes_seen + 16'h0001;
               if (bytes_seen == frame_len) parse_phase = sfpe_pkg::PH_SUM;
            end
            default: begin
               if (!extracting()) begin
                  restart_on(b);
               end else begin
                  r.item_kind  = sfpe_pkg::KIND_VERDICT;
                  r.frame_good = (b == frame_sum);
                  r.last       = 1'b1;
                  expected_items = {expected_items, r};
                  if (r.frame_good) captured = 1'b1;
                  else restart_on(b);
               end
            end
         endcase
      endfunction

      task report(string msg);
         errors++;
         if (errors <= 40) $display("MISMATCH: %s", msg);
      endtask

      task check_result(logic kind, logic [15:0] data, logic lst);
         sfpe_pkg::result_type want;
         items_checked++;
         if (expected_items.size() == 0) begin
            report($sformatf("item %0d: unexpected kind %0d data %h last %0d",
                             items_checked, kind, data, lst));
            return;
         end
         want = expected_items.pop_front();
         if (kind !== want.item_kind)
            report($sformatf("item %0d: kind %0d, want %0d", items_checked, kind,
                             want.item_kind));
         if (data[7:0] !== want.payload_data)
            report($sformatf("item %0d: payload %h, want %h", items_checked, data[7:0],
                             want.payload_data));
         if (data[8] !== want.frame_good)
            report($sformatf("item %0d: frame_good %0d, want %0d", items_checked, data[8],
                             want.frame_good));
         if (lst !== want.last)
            report($sformatf("item %0d: last %0d, want %0d", items_checked, lst, want.last));
         if (data[15:9] !== 7'd0)
            report($sformatf("item %0d: fill bits %h not zero", items_checked, data[15:9]));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;   // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // [7:0] payload_data, [8] frame_good
   logic        rsp_tuser;           // [0] item_kind
   logic        rsp_tlast;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = sfpe_pkg::CSR_WANTED_COMMAND;
   logic [15:0] csr_data = 16'h0000;

   extractor_scoreboard sb = new();
   logic [7:0] tx_q[$];
   bit  tx_quiet = 1'b0;
   bit  rx_quiet = 1'b0;
   int  rx_hold = 0;
   int  cycle_count = 0;

   serial_frame_payload_extractor dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check_result(rsp_tuser, rsp_tdata, rsp_tlast);
   end

   // Receiver: random stall per item, plus a long hold-off when requested.
   initial begin
      int rx_wait;
      rx_wait = 0;
      forever begin
         @(posedge clock);
         if (rsp_tvalid && rsp_tready) rx_wait = rx_quiet ? 0 : int'($urandom_range(0, 8));
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else if (rx_wait > 0) begin
            rx_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Add one byte at the tail of the send queue.
   function automatic void queue_byte(logic [7:0] b);
      tx_q = {tx_q, b};
   endfunction

   // Queue one complete frame; the checksum is either right or off by a random nonzero amount.
   function automatic void push_frame(logic [7:0] ver, logic [7:0] cmd, logic [15:0] len,
                                      bit good_sum);
      logic [7:0] head [6];
      logic [7:0] s;
      logic [7:0] b;
      logic [7:0] off;
      head = '{sfpe_pkg::HDR_FIRST, sfpe_pkg::HDR_SECOND, ver, cmd, len[15:8], len[7:0]};
      s = 8'h00;
      foreach (head[i]) begin
         queue_byte(head[i]);
         s = s + head[i];
      end
      for (int i = 0; i < len; i++) begin
         b = 8'($urandom_range(0, 255));
         queue_byte(b);
         s = s + b;
      end
      off = 8'($urandom_range(1, 255));
      queue_byte(good_sum ? s : s + off);
   endfunction

   // Mostly well-formed frames with bad checksums, some noise and broken headers.
   // Only zero-length frames get a matching checksum so nothing captures early.
   function automatic void add_random_traffic();
      int r;
      int lim;
      logic [7:0] b;
      logic [7:0] cmd;
      logic [15:0] len;
      r = int'($urandom_range(0, 99));
      if (r < 8) begin
         repeat ($urandom_range(1, 4)) begin
            do b = 8'($urandom_range(0, 255));
            while (b == sfpe_pkg::HDR_FIRST || b == sfpe_pkg::HDR_SECOND);
            queue_byte(b);
         end
      end else if (r < 14) begin
         queue_byte(sfpe_pkg::HDR_FIRST);
         do b = 8'($urandom_range(0, 255)); while (b == sfpe_pkg::HDR_SECOND);
         queue_byte(b);
      end else begin
         cmd = ($urandom_range(0, 3) != 0) ? sb.wanted_cmd : 8'($urandom_range(0, 255));
         lim = int'(sb.len_limit);
         r = int'($urandom_range(0, 9));
         if (r == 0) len = 16'h0000;
         else if (r == 1 && lim < 40) len = 16'(lim + int'($urandom_range(1, 3)));
         else len = 16'($urandom_range(1, (lim >= 1 && lim < 12) ? lim : 12));
         push_frame(8'($urandom_range(0, 255)), cmd, len,
                    len == 0 && $urandom_range(0, 1) == 1);
      end
   endfunction

   // Called at a clock edge; returns at the edge that accepts the byte.
   task automatic send_byte(logic [7:0] b, int gap);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      sb.parse_byte(b);
   endtask

   task automatic drive_bytes(int n);
      repeat (n) begin
         if (tx_q.size() == 0) add_random_traffic();
         send_byte(tx_q.pop_front(), tx_quiet ? 0 : int'($urandom_range(0, 8)));
      end
      req_tvalid <= 1'b0;
   endtask

   task automatic write_regs(logic [7:0] cmd, logic [15:0] limit);
      csr_valid <= 1'b1;
      csr_index <= sfpe_pkg::CSR_WANTED_COMMAND;
      csr_data  <= {8'h00, cmd};
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(sfpe_pkg::CSR_WANTED_COMMAND, {8'h00, cmd});
      csr_index <= sfpe_pkg::CSR_MAX_LENGTH;
      csr_data  <= limit;
      do @(posedge clock); while (!csr_ready);
      sb.set_reg(sfpe_pkg::CSR_MAX_LENGTH, limit);
      csr_valid <= 1'b0;
   endtask

   // Hold the sender until every expected item is out, then cover the pipeline latency.
   task automatic wait_drained();
      while (sb.expected_items.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   initial begin
      logic [7:0]  cmd;
      logic [15:0] limit;
      int          n;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: zero-length frame, broken header, unwanted command, bad verdict.
      push_frame(8'hFF, 8'h00, 16'd0, 1'b1);
      queue_byte(sfpe_pkg::HDR_FIRST);
      queue_byte(8'h00);
      push_frame(8'h00, 8'h02, 16'd1, 1'b1);
      push_frame(8'h5A, sfpe_pkg::WANTED_CMD_RST, 16'd1, 1'b0);
      drive_bytes(tx_q.size());
      wait_drained();

      for (int p = 0; p < 14; p++) begin
         n = 100;
         case (p)
            0: begin cmd = 8'h00; limit = 16'h0000; end
            1: begin cmd = 8'hFF; limit = 16'hFFFF; end
            2: begin cmd = 8'h55; limit = 16'h0001; end
            3: begin cmd = 8'hAA; limit = 16'd256; end
            default: begin
               cmd = 8'($urandom_range(0, 255));
               limit = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'($urandom_range(1, 16));
            end
         endcase
         // Chunks end mid-frame, so registers also change in the middle of frames.
         write_regs(cmd, limit);
         tx_quiet = ($urandom_range(0, 3) == 0);
         rx_quiet = ($urandom_range(0, 3) == 0);
         if (p == 1) begin
            // Flood the input while the output is held off for a long stretch.
            tx_quiet = 1'b1;
            rx_hold  = 250;
         end
         if (p == 3) begin
            push_frame(8'($urandom_range(0, 255)), 8'hAA, 16'd256, 1'b0);
            n = tx_q.size() + 40;
         end
         drive_bytes(n);
         wait_drained();
      end

      // Finish pending frames, then capture one good frame; all later bytes are ignored.
      drive_bytes(tx_q.size());
      wait_drained();
      write_regs(8'h3C, 16'd8);
      tx_quiet = 1'b0;
      rx_quiet = 1'b0;
      push_frame(8'($urandom_range(0, 255)), 8'h3C, 16'd5, 1'b1);
      push_frame(8'($urandom_range(0, 255)), 8'h3C, 16'd5, 1'b1);
      repeat (8) queue_byte(8'($urandom_range(0, 255)));
      drive_bytes(tx_q.size());
      wait_drained();
      repeat (20) @(posedge clock);

      if (sb.expected_items.size() != 0)
         sb.report($sformatf("%0d expected items never arrived", sb.expected_items.size()));
      if (sb.errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
